@@ rtl/core/xor_checked_command_frame_receiver_top_defines.svh @@
// Assertion macros for the checker in xcfr_checker.sv.
`ifndef XOR_CHECKED_COMMAND_FRAME_RECEIVER_TOP_DEFINES_SVH
`define XOR_CHECKED_COMMAND_FRAME_RECEIVER_TOP_DEFINES_SVH

// Clocked property, off while reset is asserted (active low reset).
`define XCFR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("xcfr assertion failed");

// Clocked property that also holds during reset.
`define XCFR_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("xcfr assertion failed");

`endif

@@ rtl/core/xcfr_pkg.sv @@
package xcfr_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned MASK_WORDS = 4;

  localparam logic [BYTE_W-1:0] START_BYTE = 8'h3D;  // '='

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HANDLER_MASK_0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HANDLER_MASK_1 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HANDLER_MASK_2 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HANDLER_MASK_3 = 8'd3;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DISPATCH   = 2'd0,
    ST_BAD_CHECK  = 2'd1,
    ST_NO_HANDLER = 2'd2
  } status_e;

  // Frame position, one-hot
  typedef enum logic [3:0] {
    POS_START = 4'b0001,
    POS_CMD   = 4'b0010,
    POS_DATA  = 4'b0100,
    POS_CHECK = 4'b1000
  } frame_pos_e;

endpackage

@@ rtl/core/xcfr_rx_if.sv @@
// Received byte channel
interface xcfr_rx_if import xcfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/core/xcfr_res_if.sv @@
// Frame result channel
interface xcfr_res_if import xcfr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   command;
  logic [BYTE_W-1:0]   payload;

  modport source (output valid, output status, output command, output payload, input ready);
  modport sink   (input valid, input status, input command, input payload, output ready);
endinterface

@@ rtl/core/xor_checked_command_frame_receiver_top.sv @@
// The result of a frame is registered and valid in the cycle after its check byte is taken.
// Throughput: one byte per cycle; ready drops only while a result is held and
// the sink is stalled (single output register).
// Reset: clears frame position, running XOR, handler masks and result valid;
// the command and data holds are loaded by each frame before use.
module xor_checked_command_frame_receiver_top import xcfr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  xcfr_rx_if.sink               rx_i,
  xcfr_res_if.source            res_o
);

  logic [MASK_WORDS-1:0][CFG_DATA_W-1:0] handler_mask_q;

  frame_pos_e        pos_q, pos_d;
  logic [BYTE_W-1:0] xor_q, xor_d;
  logic [BYTE_W-1:0] cmd_hold_q;
  logic [BYTE_W-1:0] data_hold_q;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q;
  logic [BYTE_W-1:0]   out_cmd_q;
  logic [BYTE_W-1:0]   out_data_q;

  logic          rx_fire;
  logic          frame_done;
  logic          handler_hit;
  status_e       status_new;

  // Byte is taken while the output register is empty or draining
  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign rx_fire    = rx_i.valid && rx_i.ready;

  // Handler mask writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      handler_mask_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HANDLER_MASK_0: handler_mask_q[0] <= cfg_data_i;
        REG_HANDLER_MASK_1: handler_mask_q[1] <= cfg_data_i;
        REG_HANDLER_MASK_2: handler_mask_q[2] <= cfg_data_i;
        REG_HANDLER_MASK_3: handler_mask_q[3] <= cfg_data_i;
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // Frame position and running XOR
  always_comb begin
    pos_d      = pos_q;
    xor_d      = xor_q;
    frame_done = 1'b0;
    if (rx_fire) begin
      unique case (pos_q)
        POS_START: begin
          if (rx_i.rx_byte == START_BYTE) begin
            pos_d = POS_CMD;
            xor_d = rx_i.rx_byte;
          end
        end
        POS_CMD: begin
          pos_d = POS_DATA;
          xor_d = xor_q ^ rx_i.rx_byte;
        end
        POS_DATA: begin
          pos_d = POS_CHECK;
          xor_d = xor_q ^ rx_i.rx_byte;
        end
        POS_CHECK: begin
          pos_d      = POS_START;
          xor_d      = '0;
          frame_done = 1'b1;
        end
        default: begin
          pos_d = POS_START;
          xor_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_START;
      xor_q <= '0;
    end else begin
      pos_q <= pos_d;
      xor_q <= xor_d;
    end
  end

  // Command and data holds
  always_ff @(posedge clk_i) begin
    if (rx_fire && (pos_q == POS_CMD)) begin
      cmd_hold_q <= rx_i.rx_byte;
    end
    if (rx_fire && (pos_q == POS_DATA)) begin
      data_hold_q <= rx_i.rx_byte;
    end
  end

  // Check and handler lookup on the last byte
  assign handler_hit = handler_mask_q[cmd_hold_q[7:6]][cmd_hold_q[5:0]];

  always_comb begin
    priority if ((xor_q ^ rx_i.rx_byte) != '0) begin
      status_new = ST_BAD_CHECK;
    end else if (!handler_hit) begin
      status_new = ST_NO_HANDLER;
    end else begin
      status_new = ST_DISPATCH;
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (frame_done) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_done) begin
      out_status_q <= status_new;
      out_cmd_q    <= cmd_hold_q;
      out_data_q   <= data_hold_q;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.status  = out_status_q;
  assign res_o.command = out_cmd_q;
  assign res_o.payload = out_data_q;

endmodule

@@ rtl/core/xcfr_checker.sv @@
`include "xor_checked_command_frame_receiver_top_defines.svh"

// Port-level checks on the frame receiver
module xcfr_checker import xcfr_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                rx_valid_i,
  input logic                rx_ready_i,
  input logic                res_valid_i,
  input logic                res_ready_i,
  input logic [STATUS_W-1:0] res_status_i,
  input logic [BYTE_W-1:0]   res_command_i,
  input logic [BYTE_W-1:0]   res_payload_i
);

  // Stalled result holds its transaction
  `XCFR_ASSERT(a_res_hold, clk_i, rst_ni, (res_valid_i && !res_ready_i) |=> (res_valid_i && $stable(res_status_i) && $stable(res_command_i) && $stable(res_payload_i)))

  // Only the three defined status codes appear
  `XCFR_ASSERT(a_status_code, clk_i, rst_ni, res_valid_i |-> (res_status_i != 2'd3))

  // A new result always follows an accepted byte
  `XCFR_ASSERT(a_res_cause, clk_i, rst_ni, $rose(res_valid_i) |-> $past(rx_valid_i && rx_ready_i))

  // After a result is taken, the next one needs another byte
  `XCFR_ASSERT(a_res_no_repeat, clk_i, rst_ni, (res_valid_i && res_ready_i) |=> (!res_valid_i || $past(rx_valid_i && rx_ready_i)))

  // Receiver never blocks while no result is pending
  `XCFR_ASSERT_ALWAYS(a_ready_when_empty, clk_i, (rst_ni && !res_valid_i) |-> rx_ready_i)

endmodule

bind xor_checked_command_frame_receiver_top xcfr_checker u_xcfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rx_valid_i    (rx_i.valid),
  .rx_ready_i    (rx_i.ready),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_status_i  (res_o.status),
  .res_command_i (res_o.command),
  .res_payload_i (res_o.payload)
);

@@ tb/testbench.sv @@
module testbench;
  import xcfr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int N_PHASES       = 6;
  localparam int PHASE_ITEMS    = 187;
  localparam int N_DIR          = 31;

  // Index past the last handler mask; writes there must not land anywhere
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(MASK_WORDS);
  localparam int unsigned          REG_IDX_TOP  = (1 << CFG_IDX_W) - 1;

  typedef struct packed {
    status_e           status;
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] payload;
  } frame_res_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [BYTE_W-1:0]     rx_byte;
    logic                  pinned;
    frame_res_t            res;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  xcfr_rx_if  rx_ch ();
  xcfr_res_if res_ch ();

  xor_checked_command_frame_receiver_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rx_i       (rx_ch),
    .res_o      (res_ch)
  );

  // Predictor state: frame assembly and handler masks
  frame_pos_e            frame_pos = POS_START;
  logic [BYTE_W-1:0]     held_cmd  = '0;
  logic [BYTE_W-1:0]     held_pay  = '0;
  logic [BYTE_W-1:0]     chk_acc   = '0;
  logic [CFG_DATA_W-1:0] handler_mask [MASK_WORDS] = '{default: '0};

  frame_res_t  pending_frames [$];
  frame_res_t  pin_res;
  bit          pin_set = 1'b0;
  bit          idle_on = 1'b1;
  int          fails = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  int unsigned fed = 0;
  stim_row_t   dir_tbl [N_DIR];

  always #5 clk_i = ~clk_i;

  // Advance the frame by one accepted byte; returns 1 when a frame completes
  function automatic bit frame_step(input logic [BYTE_W-1:0] b, output frame_res_t r);
    r = '0;
    case (frame_pos)
      POS_START: begin
        if (b == START_BYTE) begin
          chk_acc   = b;
          frame_pos = POS_CMD;
        end
      end
      POS_CMD: begin
        held_cmd  = b;
        chk_acc   = chk_acc ^ b;
        frame_pos = POS_DATA;
      end
      POS_DATA: begin
        held_pay  = b;
        chk_acc   = chk_acc ^ b;
        frame_pos = POS_CHECK;
      end
      default: begin
        r.command = held_cmd;
        r.payload = held_pay;
        if ((chk_acc ^ b) != '0) begin
          r.status = ST_BAD_CHECK;
        end else if (!handler_mask[held_cmd[7:6]][held_cmd[5:0]]) begin
          r.status = ST_NO_HANDLER;
        end else begin
          r.status = ST_DISPATCH;
        end
        frame_pos = POS_START;
        chk_acc   = '0;
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic stim_row_t byte_row(input logic [BYTE_W-1:0] b);
    stim_row_t r;
    r         = '0;
    r.kind    = ROW_BYTE;
    r.rx_byte = b;
    return r;
  endfunction

  function automatic stim_row_t end_row(input logic [BYTE_W-1:0] b, input status_e st,
                                        input logic [BYTE_W-1:0] c,
                                        input logic [BYTE_W-1:0] p);
    stim_row_t r;
    r           = byte_row(b);
    r.pinned    = 1'b1;
    r.res       = '{st, c, p};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = val;
    return r;
  endfunction

  // Command and data bytes lean toward the extremes and the start byte
  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return START_BYTE;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] mask_value(input int ph, input bit odd);
    case (ph)
      1:       return '1;
      2:       return '0;
      4:       return odd ? 64'h5555_5555_5555_5555 : 64'hAAAA_AAAA_AAAA_AAAA;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Send one byte, with an occasional gap ahead of it
  task automatic put_byte(input logic [BYTE_W-1:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk_i); while (rx_ch.ready !== 1'b1);
    @(negedge clk_i);
  endtask

  // Hold the sender until every expected frame result is out
  task automatic settle();
    rx_ch.valid <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx < MASK_WORDS) handler_mask[idx[1:0]] = val;
    @(negedge clk_i);
  endtask

  // Mostly whole frames (some with a bad check), plus stray and truncated bytes
  task automatic feed_random();
    int                kind;
    int                extra;
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] dat;
    logic [BYTE_W-1:0] chk;
    kind = $urandom_range(0, 99);
    if (kind < 75) begin
      cmd = pick_byte();
      dat = pick_byte();
      chk = START_BYTE ^ cmd ^ dat;
      if ($urandom_range(0, 4) == 0) chk = chk ^ BYTE_W'($urandom_range(1, 255));
      put_byte(START_BYTE);
      put_byte(cmd);
      put_byte(dat);
      put_byte(chk);
      fed += 4;
    end else if (kind < 88) begin
      // line noise; dropped when no frame is open
      dat = BYTE_W'($urandom);
      if (dat == START_BYTE) dat = ~dat;
      put_byte(dat);
      fed++;
    end else begin
      // frame cut short; following bytes become its content
      extra = $urandom_range(0, 2);
      put_byte(START_BYTE);
      fed++;
      repeat (extra) begin
        put_byte(BYTE_W'($urandom));
        fed++;
      end
    end
  endtask

  // Result sink: random stall bursts while idling is on
  always @(negedge clk_i) begin
    if (!idle_on) begin
      res_ch.ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 3);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Transaction monitor: predict on input, compare on output, watchdog
  always @(posedge clk_i) begin
    frame_res_t got_exp;
    frame_res_t pred;
    bit         done;
    bit         moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1) begin
        moved = 1'b1;
        done  = frame_step(rx_ch.rx_byte, pred);
        if (pin_set) begin
          pending_frames.push_back(pin_res);
          pin_set = 1'b0;
        end else if (done) begin
          pending_frames.push_back(pred);
        end
      end
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        moved = 1'b1;
        if (pending_frames.size() == 0) begin
          $error("unexpected result: status %0d command %0h payload %0h",
                 res_ch.status, res_ch.command, res_ch.payload);
          fails++;
        end else begin
          got_exp = pending_frames.pop_front();
          if (res_ch.status !== got_exp.status) begin
            $error("status: expected %0d, got %0d", got_exp.status, res_ch.status);
            fails++;
          end
          if (res_ch.command !== got_exp.command) begin
            $error("command: expected %0h, got %0h", got_exp.command, res_ch.command);
            fails++;
          end
          if (res_ch.payload !== got_exp.payload) begin
            $error("payload: expected %0h, got %0h", got_exp.payload, res_ch.payload);
            fails++;
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Stimulus sequence
  initial begin
    int          ph;
    int unsigned target;
    int unsigned pause_at;
    bit          paused;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    res_ch.ready  = 1'b0;

    dir_tbl = '{
      // reset masks: stray bytes, then no-handler and bad-check frames
      byte_row(8'h00),
      byte_row(8'hFF),
      byte_row(START_BYTE),
      byte_row(8'h00),
      byte_row(8'h00),
      end_row(START_BYTE, ST_NO_HANDLER, 8'h00, 8'h00),
      byte_row(START_BYTE),
      byte_row(8'hFF),
      byte_row(8'hFF),
      end_row(8'h00, ST_BAD_CHECK, 8'hFF, 8'hFF),
      // start byte inside a frame is plain content
      byte_row(START_BYTE),
      byte_row(START_BYTE),
      byte_row(START_BYTE),
      end_row(START_BYTE, ST_NO_HANDLER, START_BYTE, START_BYTE),
      cfg_row(REG_HANDLER_MASK_0, '1),
      cfg_row(REG_HANDLER_MASK_1, '0),
      cfg_row(REG_HANDLER_MASK_2, 64'h0000_0000_0000_0001),
      cfg_row(REG_HANDLER_MASK_3, 64'h8000_0000_0000_0000),
      cfg_row(REG_UNMAPPED, '0),
      // lowest and highest command dispatch, first command of word 1 has none
      byte_row(START_BYTE),
      byte_row(8'h00),
      byte_row(8'hA5),
      end_row(8'h98, ST_DISPATCH, 8'h00, 8'hA5),
      byte_row(START_BYTE),
      byte_row(8'hFF),
      byte_row(8'h5A),
      end_row(8'h98, ST_DISPATCH, 8'hFF, 8'h5A),
      byte_row(START_BYTE),
      byte_row(8'h40),
      byte_row(8'h00),
      end_row(8'h7D, ST_NO_HANDLER, 8'h40, 8'h00)
    };

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table
    for (int i = 0; i < N_DIR; i++) begin
      if (dir_tbl[i].kind == ROW_CFG) begin
        settle();
        write_reg(dir_tbl[i].idx, dir_tbl[i].data);
      end else begin
        pin_res = dir_tbl[i].res;
        pin_set = dir_tbl[i].pinned;
        put_byte(dir_tbl[i].rx_byte);
      end
    end

    // Random phases, each with its own mask setting; phase 2 and the last run flat out
    for (ph = 0; ph < N_PHASES; ph++) begin
      settle();
      idle_on = (ph != 2) && (ph != N_PHASES - 1);
      write_reg(REG_HANDLER_MASK_0, mask_value(ph, 1'b0));
      write_reg(REG_HANDLER_MASK_1, mask_value(ph, 1'b1));
      write_reg(REG_HANDLER_MASK_2, mask_value(ph, 1'b0));
      write_reg(REG_HANDLER_MASK_3, mask_value(ph, 1'b1));
      write_reg(CFG_IDX_W'($urandom_range(MASK_WORDS, REG_IDX_TOP)), {$urandom, $urandom});
      target   = fed + PHASE_ITEMS;
      pause_at = fed + $urandom_range(20, PHASE_ITEMS - 20);
      paused   = 1'b0;
      while (fed < target) begin
        if (!paused && fed >= pause_at) begin
          settle();
          paused = 1'b1;
        end
        feed_random();
      end
    end

    rx_ch.valid <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
